// File: sv/sitd_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds character codes, conversion step size and digit-count helper.
// No dependencies.
`default_nettype none

package sitd_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned BITS_PER_CYCLE  = 4;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [3:0] BCD_FIVE = 4'd5;
  localparam logic [3:0] BCD_ADJ  = 4'd3;

  // decimal digits of 2**(w-1)
  function automatic int unsigned num_digits(input int unsigned w);
    return ((w - 1) * 30103) / 100000 + 1;
  endfunction

endpackage

`default_nettype wire

// File: sv/sitd_if.sv
// Channel interfaces for the converter: value beats in, character beats out.
// Uses no package.
`default_nettype none

interface sitd_in_if #(
  parameter int unsigned W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_char;

  modport source (output valid, output char_out, output last_char, input ready);
  modport sink   (input valid, input char_out, input last_char, output ready);
endinterface

`default_nettype wire

// File: sv/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text, most significant character first.
// The BCD conversion handles 4 bits per cycle; the front end takes a new value
// only once the previous result has been pushed into the queue.
// Throughput: one character per cycle while the output is ready.
// Reset: asynchronous, active low; clears control state only, no clearing pass.
`default_nettype none

module signed_int_to_decimal_ascii import sitd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sitd_in_if.sink   in_i,
  sitd_out_if.source out_o
);

  localparam int unsigned BCD_W = 4 * num_digits(VALUE_WIDTH);

  logic           push_valid, push_ready;
  logic [BCD_W:0] push_data;
  logic           pop_valid, pop_ready;
  logic [BCD_W:0] pop_data;

  sitd_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .BCD_W       (BCD_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  sitd_fifo #(
    .DW (BCD_W + 1)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  sitd_back #(
    .BCD_W (BCD_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// File: sv/sitd_front.sv
// Front end: accepts a value, forms sign and magnitude, converts to BCD.
// Depends on sitd_pkg and sitd_in_if.
`default_nettype none

module sitd_front import sitd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned BCD_W       = 4 * num_digits(VALUE_WIDTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  sitd_in_if.sink            in_i,
  output logic               push_valid_o,
  input  wire logic          push_ready_i,
  output logic [BCD_W:0]     push_data_o
);

  localparam int unsigned STEPS = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int unsigned PW    = STEPS * BITS_PER_CYCLE;
  localparam int unsigned CNTW  = $clog2(STEPS + 1);
  localparam int unsigned ND    = BCD_W / 4;

  function automatic logic [BCD_W-1:0] dab(input logic [BCD_W-1:0] b, input logic bit_in);
    logic [BCD_W-1:0] t;
    logic [3:0]       nib;
    t = b;
    for (int d = 0; d < ND; d++) begin
      nib = t[d*4 +: 4];
      if (nib >= BCD_FIVE) begin
        nib = nib + BCD_ADJ;
      end
      t[d*4 +: 4] = nib;
    end
    return {t[BCD_W-2:0], bit_in};
  endfunction

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic                   neg_q, neg_d;
  logic [CNTW-1:0]        cnt_q, cnt_d;
  logic [PW-1:0]          sr_q, sr_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BCD_W-1:0]       bstep;
  logic [PW-1:0]          sstep;
  logic                   accept;

  assign raw         = in_i.value;
  assign mag         = raw[VALUE_WIDTH-1] ? VALUE_WIDTH'(~raw + 1'b1) : raw;
  assign in_i.ready  = !busy_q && !done_q;
  assign accept      = in_i.valid && in_i.ready;

  assign push_valid_o = done_q;
  assign push_data_o  = {neg_q, bcd_q};

  always_comb begin
    bstep = bcd_q;
    sstep = sr_q;
    for (int k = 0; k < BITS_PER_CYCLE; k++) begin
      bstep = dab(bstep, sstep[PW-1]);
      sstep = {sstep[PW-2:0], 1'b0};
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    sr_d   = sr_q;
    bcd_d  = bcd_q;
    if (accept) begin
      busy_d = 1'b1;
      neg_d  = raw[VALUE_WIDTH-1];
      cnt_d  = CNTW'(STEPS);
      sr_d   = PW'(mag);
      bcd_d  = '0;
    end else if (busy_q) begin
      sr_d  = sstep;
      bcd_d = bstep;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (done_q && push_ready_i) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    sr_q  <= sr_d;
    bcd_q <= bcd_d;
  end

endmodule

`default_nettype wire

// File: sv/sitd_fifo.sv
// Short queue between the front and back ends; holds sign and BCD digits.
// Depends on sitd_pkg.
`default_nettype none

module sitd_fifo import sitd_pkg::*; #(
  parameter int unsigned DW = 4 * num_digits(VALUE_WIDTH_DEF) + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire logic [DW-1:0] push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output logic [DW-1:0]      pop_data_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != CW'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/sitd_back.sv
// Back end: takes sign and BCD digits, emits ASCII characters one per beat.
// Depends on sitd_pkg and sitd_out_if.
`default_nettype none

module sitd_back import sitd_pkg::*; #(
  parameter int unsigned BCD_W = 4 * num_digits(VALUE_WIDTH_DEF)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         pop_valid_i,
  output logic              pop_ready_o,
  input  wire logic [BCD_W:0] pop_data_i,
  sitd_out_if.source        out_o
);

  localparam int unsigned ND   = BCD_W / 4;
  localparam int unsigned IDXW = $clog2(ND);

  logic             busy_q;
  logic             negp_q;
  logic [IDXW-1:0]  idx_q;
  logic [BCD_W-1:0] bcd_q;
  logic             ovalid_q;
  logic [7:0]       char_q;
  logic             last_q;
  logic             adv;
  logic             last_emit;
  logic             load;
  logic [IDXW-1:0]  lead;
  logic [3:0]       nib;

  assign adv         = !ovalid_q || out_o.ready;
  assign last_emit   = busy_q && !negp_q && (idx_q == '0);
  assign pop_ready_o = !busy_q || (adv && last_emit);
  assign load        = pop_valid_i && pop_ready_o;
  assign nib         = bcd_q[idx_q*4 +: 4];

  assign out_o.valid     = ovalid_q;
  assign out_o.char_out  = char_q;
  assign out_o.last_char = last_q;

  always_comb begin
    lead = '0;
    for (int d = 0; d < ND; d++) begin
      if (pop_data_i[d*4 +: 4] != 4'd0) begin
        lead = IDXW'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (adv) begin
        ovalid_q <= busy_q;
      end
      if (load) begin
        busy_q <= 1'b1;
      end else if (adv && last_emit) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && busy_q) begin
      if (negp_q) begin
        char_q <= CH_MINUS;
        last_q <= 1'b0;
      end else begin
        char_q <= CH_ZERO + {4'd0, nib};
        last_q <= idx_q == '0;
      end
    end
    if (load) begin
      bcd_q  <= pop_data_i[BCD_W-1:0];
      negp_q <= pop_data_i[BCD_W];
      idx_q  <= lead;
    end else if (adv && busy_q) begin
      if (negp_q) begin
        negp_q <= 1'b0;
      end else begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
